FILE: sv/pblc_pkg.sv
// Shared types, codes and constants for the pending bind list compactor.
`default_nettype none

package pblc_pkg;

  // Default list capacity and the fixed field widths of the words.
  localparam int PBLC_DEPTH = 32;
  localparam int LEN_W      = 6;
  localparam int ELEM_W     = 16;
  localparam int SEQ_W      = 16;
  localparam int CYC_W      = 31;

  // Operation codes carried in the mode field.
  typedef enum logic [1:0] {
    MD_ADD  = 2'd0,
    MD_DROP = 2'd1,
    MD_KEEP = 2'd2,
    MD_READ = 2'd3
  } mode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_KEEP_ERR = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINISH
  } state_t;

  // One stored bind record.
  typedef struct packed {
    logic [ELEM_W-1:0] elem_id;
    logic [SEQ_W-1:0]  sequence_id;
    logic [CYC_W-1:0]  begin_cycle;
  } rec_t;

  // Controls broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic shift;
    logic load;
  } pblc_ctl_t;

  // Width of a cell index for a given depth, at least one bit.
  function automatic int idx_width(input int depth);
    idx_width = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pblc_if.sv
// Handshake interfaces for the request and result channels of the compactor.
`default_nettype none

interface pblc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] elem_id;
  logic [15:0] sequence_id;
  logic [30:0] begin_cycle;
  logic [5:0]  count_or_index;

  modport source (output valid, mode, elem_id, sequence_id, begin_cycle, count_or_index,
                  input ready);
  modport sink   (input valid, mode, elem_id, sequence_id, begin_cycle, count_or_index,
                  output ready);
endinterface

interface pblc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  length;
  logic [15:0] out_elem_id;
  logic [15:0] out_sequence_id;
  logic [30:0] out_begin_cycle;

  modport source (output valid, status, length, out_elem_id, out_sequence_id,
                  out_begin_cycle, input ready);
  modport sink   (input valid, status, length, out_elem_id, out_sequence_id,
                  out_begin_cycle, output ready);
endinterface

`default_nettype wire

FILE: sv/pending_bind_list_compactor.sv
// Top level of the pending bind list compactor: controller and the row of record cells.
//
// The list lives in a row of DEPTH cells that behaves as a shift-register queue, record 0 at
// the head. Add writes the tail cell and keep only moves the length, so those words, and reads
// outside the list, pass from the finish state straight into the result register. Drop and
// read walk the list once: every cycle the head record leaves the row and, unless it is being
// dropped, is written back at the tail. A new word is taken only once the previous one has
// finished; the result register holds a finished word until the sink takes it. Reset empties
// the list at once.
`default_nettype none

module pending_bind_list_compactor #(
  parameter int DEPTH = pblc_pkg::PBLC_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pblc_in_if.sink     req,
  pblc_out_if.source  rsp
);
  import pblc_pkg::*;

  localparam int IW = idx_width(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > LEN_W) ? CW : LEN_W;

  state_t          state, state_next;
  logic [CW-1:0]   count, count_next;
  logic [CW-1:0]   total, step, idx;
  logic [CW-1:0]   cnt_m1;
  mode_t           op, req_mode;
  logic [ELEM_W-1:0] key;
  status_t         res_status, acc_status;
  rec_t            res_rec;
  logic            rsp_valid_r;
  status_t         out_status;
  logic [LEN_W-1:0] out_len;
  rec_t            out_rec;

  rec_t            cell_data [DEPTH];
  rec_t            right     [DEPTH];
  pblc_ctl_t       ctl;
  logic [IW-1:0]   load_idx;
  rec_t            load_data;

  rec_t            in_rec, head;
  logic            accept, keep_head, last_step, out_free, full;
  logic [XW-1:0]   count_x, n_x;

  // Request decode and walk helpers.
  assign req_mode   = mode_t'(req.mode);
  assign in_rec     = '{elem_id: req.elem_id, sequence_id: req.sequence_id,
                        begin_cycle: req.begin_cycle};
  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign head       = cell_data[0];
  assign keep_head  = (op == MD_READ) || (head.elem_id != key);
  assign cnt_m1     = count - 1'b1;
  assign last_step  = (step == (total - 1'b1));
  assign count_x    = XW'(count);
  assign n_x        = XW'(req.count_or_index);
  assign full       = (count_x >= XW'(DEPTH));
  assign out_free   = !rsp_valid_r || rsp.ready;

  // Status of a word as it is accepted.
  always_comb begin
    acc_status = ST_OK;
    case (req_mode)
      MD_ADD:  acc_status = full ? ST_FULL : ST_OK;
      MD_DROP: acc_status = ST_OK;
      MD_KEEP: acc_status = (n_x > count_x) ? ST_KEEP_ERR : ST_OK;
      MD_READ: acc_status = (n_x >= count_x) ? ST_RANGE : ST_OK;
      default: acc_status = ST_OK;
    endcase
  end

  // Next state, next length and the controls for the cell row.
  always_comb begin
    state_next = state;
    count_next = count;
    ctl        = '0;
    load_idx   = count[IW-1:0];
    load_data  = in_rec;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_FINISH;
          case (req_mode)
            MD_ADD: begin
              if (!full) begin
                ctl.load   = 1'b1;
                count_next = count + 1'b1;
              end
            end
            MD_DROP: begin
              if (count != '0) begin
                state_next = S_WALK;
              end
            end
            MD_KEEP: begin
              if (n_x <= count_x) begin
                count_next = n_x[CW-1:0];
              end
            end
            MD_READ: begin
              if (n_x < count_x) begin
                state_next = S_WALK;
              end
            end
            default: state_next = S_FINISH;
          endcase
        end
      end
      S_WALK: begin
        ctl.shift = 1'b1;
        ctl.load  = keep_head;
        load_idx  = cnt_m1[IW-1:0];
        load_data = head;
        if (!keep_head) begin
          count_next = cnt_m1;
        end
        if (last_step) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      rsp_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_FINISH && out_free) begin
        rsp_valid_r <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_r <= 1'b0;
      end
    end
  end

  // Operation context and the pending result.
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= req_mode;
      key        <= req.elem_id;
      idx        <= n_x[CW-1:0];
      total      <= count;
      step       <= '0;
      res_status <= acc_status;
      res_rec    <= '0;
    end else if (state == S_WALK) begin
      step <= step + 1'b1;
      if (op == MD_READ && step == idx) begin
        res_rec <= head;
      end
    end
  end

  // Result register towards the sink.
  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      out_status <= res_status;
      out_len    <= count_x[LEN_W-1:0];
      out_rec    <= res_rec;
    end
  end

  assign rsp.valid           = rsp_valid_r;
  assign rsp.status          = out_status;
  assign rsp.length          = out_len;
  assign rsp.out_elem_id     = out_rec.elem_id;
  assign rsp.out_sequence_id = out_rec.sequence_id;
  assign rsp.out_begin_cycle = out_rec.begin_cycle;

  // The row of cells; the last cell shifts in an empty record.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      assign right[i] = '0;
    end else begin : g_body
      assign right[i] = cell_data[i+1];
    end
    pblc_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load_idx  (load_idx),
      .load_data (load_data),
      .right     (right[i]),
      .data      (cell_data[i])
    );
  end

endmodule

`default_nettype wire

FILE: sv/pblc_cell.sv
// One cell of the record row: holds a single record and takes its right neighbour's on a shift.
`default_nettype none

module pblc_cell #(
  parameter int DEPTH = pblc_pkg::PBLC_DEPTH,
  parameter int INDEX = 0
) (
  input  wire logic                                     clk,
  input  wire pblc_pkg::pblc_ctl_t                      ctl,
  input  wire logic [pblc_pkg::idx_width(DEPTH)-1:0]    load_idx,
  input  wire pblc_pkg::rec_t                           load_data,
  input  wire pblc_pkg::rec_t                           right,
  output pblc_pkg::rec_t                                data
);
  import pblc_pkg::*;

  localparam int IW = idx_width(DEPTH);

  logic hit;

  // This cell is the tail slot that the controller is writing.
  assign hit = (load_idx == IW'(INDEX));

  // A tail write wins over the shift; the record store needs no reset.
  always_ff @(posedge clk) begin
    if (ctl.load && hit) begin
      data <= load_data;
    end else if (ctl.shift) begin
      data <= right;
    end
  end

endmodule

`default_nettype wire

FILE: sv/pblc_checker.sv
// Port-level checks on the compactor's result channel, bound to the top level.
`default_nettype none

module pblc_checker #(
  parameter int DEPTH = pblc_pkg::PBLC_DEPTH
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  status,
  input wire logic [5:0]  length,
  input wire logic [15:0] out_elem_id,
  input wire logic [15:0] out_sequence_id,
  input wire logic [30:0] out_begin_cycle
);
  import pblc_pkg::*;

  // A stalled result word keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(length)
      && $stable(out_elem_id) && $stable(out_sequence_id) && $stable(out_begin_cycle))
    else $error("result word changed while stalled");

  // The list never grows past its capacity.
  a_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (DEPTH > 63) || (int'(length) <= DEPTH))
    else $error("length beyond capacity");

  // A full report only comes from a list at capacity.
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> length == 6'(DEPTH))
    else $error("full reported below capacity");

  // Any error result carries no entry.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |->
      out_elem_id == '0 && out_sequence_id == '0 && out_begin_cycle == '0)
    else $error("error result carries entry data");

endmodule

bind pending_bind_list_compactor pblc_checker #(.DEPTH(DEPTH)) u_pblc_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .status          (rsp.status),
  .length          (rsp.length),
  .out_elem_id     (rsp.out_elem_id),
  .out_sequence_id (rsp.out_sequence_id),
  .out_begin_cycle (rsp.out_begin_cycle)
);

`default_nettype wire

FILE: tb/pending_bind_list_compactor_tb.sv
// Self-checking testbench for the pending bind list compactor, with its own list predictor.
`default_nettype none

module pending_bind_list_compactor_tb;
  import pblc_pkg::*;

  // One request word as offered on the request channel.
  typedef struct packed {
    mode_t             mode;
    logic [ELEM_W-1:0] elem_id;
    logic [SEQ_W-1:0]  sequence_id;
    logic [CYC_W-1:0]  begin_cycle;
    logic [LEN_W-1:0]  count_or_index;
  } bind_word_t;

  // One result word as expected on the response channel.
  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] length;
    rec_t             rec;
  } list_rsp_t;

  logic clk;
  logic rst;

  pblc_in_if  req_if ();
  pblc_out_if rsp_if ();

  pending_bind_list_compactor DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // Words still to be offered, and results still to be seen.
  bind_word_t  pending_words[$];
  list_rsp_t   want_rsp[$];

  // Shadow copy of the list, updated as each word is accepted.
  rec_t        shadow_rec[PBLC_DEPTH];
  int unsigned shadow_len;

  int  accepted_cnt = 0;
  int  total_items  = 0;
  int  hold_at      = 0;
  int  hold_left    = 0;
  bit  hold_done    = 0;
  bit  in_taken     = 0;
  int  bad_cnt      = 0;

  // Free-running clock, period 20.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one operation to the shadow list and returns the result it should give.
  function automatic list_rsp_t apply_list_op(bind_word_t w);
    list_rsp_t   r;
    int unsigned wr;
    r.status = ST_OK;
    r.rec    = '0;
    case (w.mode)
      MD_ADD: begin
        if (shadow_len >= PBLC_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_rec[shadow_len] = rec_t'{w.elem_id, w.sequence_id, w.begin_cycle};
          shadow_len++;
        end
      end
      MD_DROP: begin
        // Compact the survivors towards the head, keeping their order.
        wr = 0;
        for (int rd = 0; rd < shadow_len; rd++) begin
          if (shadow_rec[rd].elem_id != w.elem_id) begin
            shadow_rec[wr] = shadow_rec[rd];
            wr++;
          end
        end
        shadow_len = wr;
      end
      MD_KEEP: begin
        if (w.count_or_index > shadow_len) r.status = ST_KEEP_ERR;
        else shadow_len = w.count_or_index;
      end
      default: begin
        if (w.count_or_index >= shadow_len) r.status = ST_RANGE;
        else r.rec = shadow_rec[w.count_or_index];
      end
    endcase
    r.length = LEN_W'(shadow_len);
    return r;
  endfunction

  function automatic void queue_word(mode_t m, logic [ELEM_W-1:0] e, logic [SEQ_W-1:0] s,
                                     logic [CYC_W-1:0] c, logic [LEN_W-1:0] n);
    pending_words.push_back(bind_word_t'{m, e, s, c, n});
  endfunction

  // Element ids are drawn mostly from a small pool so that drops find matches.
  function automatic logic [ELEM_W-1:0] pick_elem();
    if ($urandom_range(0, 9) == 0) return ELEM_W'($urandom);
    return ELEM_W'($urandom_range(0, 5));
  endfunction

  function automatic void flag_bad(string msg);
    if (bad_cnt < 10) $display("%0t mismatch: %s", $realtime, msg);
    bad_cnt++;
  endfunction

  // Idle percentages for the three phases of the run, switched on accepted words.
  function automatic int tx_idle_pct();
    if (accepted_cnt < total_items / 3) return 7;
    if (accepted_cnt < (2 * total_items) / 3) return 73;
    return 0;
  endfunction

  function automatic int rx_idle_pct();
    if (accepted_cnt < total_items / 3) return 73;
    if (accepted_cnt < (2 * total_items) / 3) return 7;
    return 0;
  endfunction

  // Request driver: holds a word until it is taken, then offers the next or idles.
  always @(negedge clk) begin : req_drive
    bind_word_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !in_taken) begin
      // Word still waiting to be taken.
    end else if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct()) begin
      nxt = pending_words.pop_front();
      req_if.valid          <= 1'b1;
      req_if.mode           <= nxt.mode;
      req_if.elem_id        <= nxt.elem_id;
      req_if.sequence_id    <= nxt.sequence_id;
      req_if.begin_cycle    <= nxt.begin_cycle;
      req_if.count_or_index <= nxt.count_or_index;
    end else begin
      req_if.valid <= 1'b0;
    end
    rsp_if.ready <= !rst && hold_left == 0 && $urandom_range(0, 99) >= rx_idle_pct();
  end

  // Long receiver hold-off, once, so that the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= hold_at) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: predicts on each accepted word and checks each accepted result.
  always @(posedge clk) begin : chan_mon
    bind_word_t acc_w;
    list_rsp_t  exp_w;
    list_rsp_t  got_w;
    if (rst) begin
      shadow_len = 0;
      in_taken  <= 1'b0;
    end else begin
      in_taken <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        acc_w = bind_word_t'{mode_t'(req_if.mode), req_if.elem_id, req_if.sequence_id,
                             req_if.begin_cycle, req_if.count_or_index};
        want_rsp.push_back(apply_list_op(acc_w));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got_w = list_rsp_t'{status_t'(rsp_if.status), rsp_if.length,
                            rec_t'{rsp_if.out_elem_id, rsp_if.out_sequence_id,
                                   rsp_if.out_begin_cycle}};
        if (want_rsp.size() == 0) begin
          flag_bad($sformatf("unexpected result word %h", got_w));
        end else begin
          exp_w = want_rsp.pop_front();
          if (got_w.status !== exp_w.status || got_w.length !== exp_w.length ||
              got_w.rec.elem_id !== exp_w.rec.elem_id ||
              got_w.rec.sequence_id !== exp_w.rec.sequence_id ||
              got_w.rec.begin_cycle !== exp_w.rec.begin_cycle)
            flag_bad($sformatf("expected st=%0d len=%0d e=%h s=%h c=%h, got st=%0d len=%0d e=%h s=%h c=%h",
                               exp_w.status, exp_w.length, exp_w.rec.elem_id,
                               exp_w.rec.sequence_id, exp_w.rec.begin_cycle,
                               got_w.status, got_w.length, got_w.rec.elem_id,
                               got_w.rec.sequence_id, got_w.rec.begin_cycle));
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int kind;
    int n_add;
    bit first;
    rst                   = 1'b1;
    req_if.valid          = 1'b0;
    req_if.mode           = MD_ADD;
    req_if.elem_id        = '0;
    req_if.sequence_id    = '0;
    req_if.begin_cycle    = '0;
    req_if.count_or_index = '0;
    rsp_if.ready          = 1'b0;

    // Directed words: empty list, field extremes, drop and keep corner cases.
    queue_word(MD_READ, 16'h0, 16'h0, 31'h0, 6'd0);
    queue_word(MD_KEEP, 16'h0, 16'h0, 31'h0, 6'd0);
    queue_word(MD_KEEP, 16'h0, 16'h0, 31'h0, 6'd1);
    queue_word(MD_DROP, 16'h5, 16'h0, 31'h0, 6'd0);
    queue_word(MD_ADD,  16'h0000, 16'h0000, 31'h0, 6'd0);
    queue_word(MD_ADD,  16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 6'd63);
    queue_word(MD_ADD,  16'h1234, 16'h0001, 31'h1, 6'd0);
    queue_word(MD_ADD,  16'h0000, 16'h0002, 31'h2, 6'd0);
    for (int i = 0; i < 4; i++) queue_word(MD_READ, 16'h0, 16'h0, 31'h0, 6'(i));
    queue_word(MD_READ, 16'h0, 16'h0, 31'h0, 6'd4);
    queue_word(MD_READ, 16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF, 6'd63);
    queue_word(MD_DROP, 16'h0, 16'h0, 31'h0, 6'd0);
    queue_word(MD_READ, 16'h0, 16'h0, 31'h0, 6'd0);
    queue_word(MD_READ, 16'h0, 16'h0, 31'h0, 6'd1);
    queue_word(MD_DROP, 16'h7777, 16'h0, 31'h0, 6'd0);
    queue_word(MD_KEEP, 16'h0, 16'h0, 31'h0, 6'd2);
    queue_word(MD_KEEP, 16'h0, 16'h0, 31'h0, 6'd3);
    queue_word(MD_KEEP, 16'h0, 16'h0, 31'h0, 6'd1);
    queue_word(MD_READ, 16'h0, 16'h0, 31'h0, 6'd0);
    queue_word(MD_READ, 16'h0, 16'h0, 31'h0, 6'd1);
    queue_word(MD_KEEP, 16'h0, 16'h0, 31'h0, 6'd0);

    // Random part: fill bursts that can reach a full list, mixed runs and raw noise.
    first = 1'b1;
    while (pending_words.size() < 540) begin
      kind  = first ? 0 : $urandom_range(0, 99);
      first = 1'b0;
      if (kind < 25) begin
        n_add = $urandom_range(30, 36);
        for (int i = 0; i < n_add; i++)
          queue_word(MD_ADD, pick_elem(), SEQ_W'($urandom), CYC_W'($urandom),
                     LEN_W'($urandom));
        for (int i = 0; i < 3; i++)
          queue_word(MD_READ, ELEM_W'($urandom), SEQ_W'($urandom), CYC_W'($urandom),
                     LEN_W'($urandom_range(0, 33)));
        queue_word(MD_DROP, pick_elem(), SEQ_W'($urandom), CYC_W'($urandom),
                   LEN_W'($urandom));
      end else if (kind < 85) begin
        for (int i = 0; i < 8; i++) begin
          kind = $urandom_range(0, 99);
          if (kind < 40)
            queue_word(MD_ADD, pick_elem(), SEQ_W'($urandom), CYC_W'($urandom),
                       LEN_W'($urandom));
          else if (kind < 55)
            queue_word(MD_DROP, pick_elem(), SEQ_W'($urandom), CYC_W'($urandom),
                       LEN_W'($urandom));
          else if (kind < 70)
            queue_word(MD_KEEP, ELEM_W'($urandom), SEQ_W'($urandom), CYC_W'($urandom),
                       LEN_W'($urandom_range(0, 33)));
          else
            queue_word(MD_READ, ELEM_W'($urandom), SEQ_W'($urandom), CYC_W'($urandom),
                       LEN_W'($urandom_range(0, 33)));
        end
      end else begin
        for (int i = 0; i < 5; i++)
          queue_word(mode_t'($urandom_range(0, 3)), ELEM_W'($urandom), SEQ_W'($urandom),
                     CYC_W'($urandom), LEN_W'($urandom_range(0, 63)));
      end
    end
    total_items = pending_words.size();
    hold_at     = (2 * total_items) / 3 + 10;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for every word to be taken and every result to be seen, then drain.
    while (accepted_cnt < total_items) @(posedge clk);
    while (want_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (bad_cnt == 0) begin
      $display("[pending_bind_list_compactor] OK");
    end else begin
      $display("[pending_bind_list_compactor] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung run.
  initial begin
    #8000000;
    $display("[pending_bind_list_compactor] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
